// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define PPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/ppt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_pkg
// Types, constants and step functions of the perspective point transform.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int CoefW  = 32;
    localparam int PointW = 16;
    localparam int ProdW  = CoefW + PointW;   // one product
    localparam int SumW   = ProdW + 1;        // u, v and w
    localparam int QuoW   = 33;               // 16 integer bits and 17 fraction bits
    localparam int DivSteps = QuoW;

    localparam logic [CoefW-1:0] QMax   = 32'h7FFF_FFFF;
    localparam logic [CoefW-1:0] QMin   = 32'h8000_0000;
    localparam logic [CoefW-1:0] OneQ16 = 32'h0001_0000;

    typedef enum logic [2:0] {
        REG_COEF_XX = 3'd0,
        REG_COEF_XY = 3'd1,
        REG_COEF_XT = 3'd2,
        REG_COEF_YX = 3'd3,
        REG_COEF_YY = 3'd4,
        REG_COEF_YT = 3'd5,
        REG_PERSP_X = 3'd6,
        REG_PERSP_Y = 3'd7
    } reg_idx_t;

    // One coordinate travelling through the divider.
    typedef struct packed {
        logic [SumW-1:0] rem;    // partial remainder, below den
        logic [SumW-1:0] den;    // |w|
        logic [7:0]      low;    // numerator bits still to shift in
        logic [QuoW-1:0] quo;
        logic            neg;    // result sign
        logic            sat;    // force clamp to the bound given by neg
        logic            zero;   // force result to zero
        logic            bad;
    } lane_t;

    typedef struct packed {
        logic [CoefW-1:0] val;
        logic             bad;
    } res_t;

    // One restoring step: shift in a numerator bit, subtract if possible.
    function automatic lane_t div_step(input lane_t l);
        lane_t         o;
        logic [SumW:0] t;
        logic [SumW:0] diff;
        logic          ge;
        o    = l;
        t    = {l.rem, l.low[7]};
        diff = t - {1'b0, l.den};
        ge   = (t >= {1'b0, l.den});
        o.rem = ge ? diff[SumW-1:0] : t[SumW-1:0];
        o.low = {l.low[6:0], 1'b0};
        o.quo = {l.quo[QuoW-2:0], ge};
        return o;
    endfunction

    // Round half away from zero, apply the sign and clamp to Q16.16.
    function automatic res_t finish(input lane_t l);
        res_t          r;
        logic [QuoW:0] q2;
        q2    = ({1'b0, l.quo} + {{QuoW{1'b0}}, 1'b1}) >> 1;
        r.bad = l.bad;
        r.val = '0;
        if (l.zero) begin
            r.val = '0;
        end else if (l.sat) begin
            r.val = l.neg ? QMin : QMax;
        end else if (l.neg) begin
            if (q2 > {2'b0, QMin}) begin
                r.val = QMin;
                r.bad = 1'b1;
            end else begin
                r.val = -q2[CoefW-1:0];
            end
        end else begin
            if (q2 > {2'b0, QMax}) begin
                r.val = QMax;
                r.bad = 1'b1;
            end else begin
                r.val = q2[CoefW-1:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/perspective_point_transform.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_point_transform
// Projects a Q12.4 point through a normalized 3x3 homography to Q16.16.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata[15:0] src_x, tdata[31:16] src_y
// m_axis    out        tdata[31:0] dst_x, tdata[63:32] dst_y, tuser[0] bad_point
// cfg       in         cfg_index selects one of eight 32-bit registers
//
// One point per clock is accepted and one result per clock is given while m_tready is high.
// Stages in order: input register, multiply, sum, magnitude, range check,
// 33 divider stages (one quotient bit each) and round/clamp, then the output.
// The pipeline halts as a whole only when the output and skid registers are
// both full; s_tready is registered from the skid state.
// Reset is synchronous, active low, clears all valid bits and loads the identity coefficients.
// ----------------------------------------------------------------------------
module perspective_point_transform
    import ppt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [15:0] src_x, [31:16] src_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // [31:0] dst_x, [63:32] dst_y
    output logic [0:0]       m_tuser,    // [0] bad_point
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic [CoefW-1:0] coef_reg [8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[REG_COEF_XX] <= OneQ16;
            coef_reg[REG_COEF_XY] <= '0;
            coef_reg[REG_COEF_XT] <= '0;
            coef_reg[REG_COEF_YX] <= '0;
            coef_reg[REG_COEF_YY] <= OneQ16;
            coef_reg[REG_COEF_YT] <= '0;
            coef_reg[REG_PERSP_X] <= '0;
            coef_reg[REG_PERSP_Y] <= '0;
        end else if (cfg_we) begin
            coef_reg[cfg_index] <= cfg_wdata;
        end
    end

    logic adv;
    logic skid_v_reg;
    assign adv      = !skid_v_reg;
    assign s_tready = !skid_v_reg;

    // Stage 0: input register.
    logic              v0_reg;
    logic [PointW-1:0] x_reg, y_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (adv) v0_reg <= s_tvalid;
        if (adv) begin
            x_reg <= s_tdata[15:0];
            y_reg <= s_tdata[31:16];
        end
    end

    // Stage 1: six products.
    logic             v1_reg;
    logic [ProdW-1:0] p_reg [6];
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= v0_reg;
        if (adv) begin
            p_reg[0] <= $signed(coef_reg[REG_COEF_XX]) * $signed(x_reg);
            p_reg[1] <= $signed(coef_reg[REG_COEF_XY]) * $signed(y_reg);
            p_reg[2] <= $signed(coef_reg[REG_COEF_YX]) * $signed(x_reg);
            p_reg[3] <= $signed(coef_reg[REG_COEF_YY]) * $signed(y_reg);
            p_reg[4] <= $signed(coef_reg[REG_PERSP_X]) * $signed(x_reg);
            p_reg[5] <= $signed(coef_reg[REG_PERSP_Y]) * $signed(y_reg);
        end
    end

    // Stage 2: u and v in Q.20, w in Q.28.
    logic            v2_reg;
    logic [SumW-1:0] u_reg, vv_reg, w_reg;
    logic [SumW-1:0] tx_ext, ty_ext, one_w;
    assign tx_ext = {{(SumW-CoefW-4){coef_reg[REG_COEF_XT][CoefW-1]}},
                     coef_reg[REG_COEF_XT], 4'b0};
    assign ty_ext = {{(SumW-CoefW-4){coef_reg[REG_COEF_YT][CoefW-1]}},
                     coef_reg[REG_COEF_YT], 4'b0};
    assign one_w  = SumW'(1) << 28;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            u_reg  <= {p_reg[0][ProdW-1], p_reg[0]} + {p_reg[1][ProdW-1], p_reg[1]} + tx_ext;
            vv_reg <= {p_reg[2][ProdW-1], p_reg[2]} + {p_reg[3][ProdW-1], p_reg[3]} + ty_ext;
            w_reg  <= {p_reg[4][ProdW-1], p_reg[4]} + {p_reg[5][ProdW-1], p_reg[5]} + one_w;
        end
    end

    // Stage 3: magnitudes and signs.
    logic            v3_reg;
    logic [SumW-1:0] au_reg, av_reg, aw_reg;
    logic            su_reg, sv_reg, sw_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            au_reg <= u_reg[SumW-1]  ? -u_reg  : u_reg;
            av_reg <= vv_reg[SumW-1] ? -vv_reg : vv_reg;
            aw_reg <= w_reg[SumW-1]  ? -w_reg  : w_reg;
            su_reg <= u_reg[SumW-1];
            sv_reg <= vv_reg[SumW-1];
            sw_reg <= w_reg[SumW-1];
        end
    end

    // Stage 4: zero divisor, integer overflow check and divider setup.
    function automatic lane_t lane_init(input logic [SumW-1:0] a, input logic sa,
                                        input logic [SumW-1:0] b, input logic sb);
        lane_t l;
        logic  ovf;
        ovf    = ({8'b0, a} >= {b, 8'b0});
        l.rem  = {8'b0, a[SumW-1:8]};
        l.den  = b;
        l.low  = a[7:0];
        l.quo  = '0;
        if (b == '0) begin
            l.zero = (a == '0);
            l.sat  = (a != '0);
            l.neg  = sa;
            l.bad  = 1'b1;
        end else begin
            l.zero = 1'b0;
            l.sat  = ovf;
            l.neg  = sa ^ sb;
            l.bad  = ovf;
        end
        return l;
    endfunction

    logic  dv_reg [DivSteps+1];
    lane_t lx_reg [DivSteps+1];
    lane_t ly_reg [DivSteps+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) dv_reg[0] <= 1'b0;
        else if (adv) dv_reg[0] <= v3_reg;
        if (adv) begin
            lx_reg[0] <= lane_init(au_reg, su_reg, aw_reg, sw_reg);
            ly_reg[0] <= lane_init(av_reg, sv_reg, aw_reg, sw_reg);
        end
    end

    // Divider pipeline: one quotient bit per stage for each coordinate.
    for (genvar k = 1; k <= DivSteps; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) dv_reg[k] <= 1'b0;
            else if (adv) dv_reg[k] <= dv_reg[k-1];
            if (adv) begin
                lx_reg[k] <= div_step(lx_reg[k-1]);
                ly_reg[k] <= div_step(ly_reg[k-1]);
            end
        end
    end

    // Final stage: rounding, sign and clamp.
    logic        vf_reg;
    res_t        rx_reg, ry_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vf_reg <= 1'b0;
        else if (adv) vf_reg <= dv_reg[DivSteps];
        if (adv) begin
            rx_reg <= finish(lx_reg[DivSteps]);
            ry_reg <= finish(ly_reg[DivSteps]);
        end
    end

    logic [64:0] fin_data;
    assign fin_data = {rx_reg.bad | ry_reg.bad, ry_reg.val, rx_reg.val};

    // Output register with a skid register behind it.
    logic        out_v_reg;
    logic [64:0] out_reg, skid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (m_tready || !out_v_reg) begin
            out_v_reg  <= skid_v_reg | (vf_reg & adv);
            skid_v_reg <= 1'b0;
        end else if (vf_reg && adv) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_v_reg) begin
            out_reg <= skid_v_reg ? skid_reg : fin_data;
        end else if (vf_reg && adv) begin
            skid_reg <= fin_data;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg[63:0];
    assign m_tuser  = out_reg[64:64];

endmodule
`default_nettype wire

// ===== src/ppt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_checker
// Port-level checks of the perspective point transform.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // A stalled result transaction holds its data.
    `PPT_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset empties the output and skid registers.
    `PPT_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid && s_tready, "not empty after reset")

    // The input is held off only while a result waits that was refused before.
    `PPT_ASSERT(a_backp, aclk, aresetn, !s_tready |-> m_tvalid && !$past(m_tready), "input held off without a stall")

    // A taken result frees the skid register at once.
    `PPT_ASSERT(a_drain, aclk, aresetn, m_tvalid && m_tready && !s_tready |=> s_tready, "skid not drained")

endmodule

bind perspective_point_transform ppt_checker u_ppt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
